### hw/rtl/mct_pkg.sv
// Shared types and constants for the multichannel compare timer.
package mct_pkg;

  localparam int CNT_W        = 32;
  localparam int FUNC_W       = 3;
  localparam int CHAN_W       = 2;
  localparam int FLAGS_W      = 3;
  localparam int DIV_W        = 2;
  localparam int PRE_W        = 3;
  localparam int FIRED_W      = 4;
  localparam int CHANNELS_DEF = 4;

  localparam int FLAG_RESET_ON_MATCH = 0;
  localparam int FLAG_LEAVE_STOPPED  = 1;
  localparam int FLAG_ZERO_COUNTER   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK    = 3'd0,
    FUNC_SET_ABS = 3'd1,
    FUNC_SET_REL = 3'd2,
    FUNC_SET_PER = 3'd3,
    FUNC_CLEAR   = 3'd4,
    FUNC_START   = 3'd5,
    FUNC_STOP    = 3'd6
  } func_t;

  typedef struct packed {
    logic              en;
    func_t             func;
    logic [CHAN_W-1:0] chan;
    logic              step;
    logic              refuse;
    logic              reset_on_match;
    logic [CNT_W-1:0]  value;
    logic [CNT_W-1:0]  rel_cmp;
    logic [CNT_W-1:0]  cnt_inc;
  } chan_cmd_t;

  typedef struct packed {
    logic fired;
    logic rm_active;
  } chan_stat_t;

  typedef struct packed {
    logic               status;
    logic [FIRED_W-1:0] fired_mask;
    logic [CNT_W-1:0]   count_now;
  } result_t;

endpackage

### hw/rtl/mct_chan.sv
// One compare channel: compare and period registers, mode bits and match logic.
module mct_chan #(
  parameter int CH_IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mct_pkg::chan_cmd_t    cmd,
  output mct_pkg::chan_stat_t   stat
);
  import mct_pkg::*;

  logic [CNT_W-1:0] cmp_r, cmp_nxt;
  logic [CNT_W-1:0] period_r, period_nxt;
  logic             armed_r, armed_nxt;
  logic             periodic_r, periodic_nxt;
  logic             rm_r, rm_nxt;
  logic             sel;
  logic             fired;

  assign sel   = (int'(cmd.chan) == CH_IDX);
  assign fired = (cmd.func == FUNC_TICK) && cmd.step && armed_r && (cmp_r == cmd.cnt_inc);

  assign stat.fired     = fired;
  assign stat.rm_active = periodic_r && rm_r;

  always_comb begin
    cmp_nxt      = cmp_r;
    period_nxt   = period_r;
    armed_nxt    = armed_r;
    periodic_nxt = periodic_r;
    rm_nxt       = rm_r;
    if (cmd.en) begin
      unique case (cmd.func)
        FUNC_TICK: begin
          if (fired) begin
            if (periodic_r) begin
              if (!rm_r) begin
                cmp_nxt = cmp_r + period_r;
              end
            end else begin
              armed_nxt = 1'b0;
            end
          end
        end
        FUNC_SET_ABS, FUNC_SET_REL: begin
          if (sel) begin
            armed_nxt    = 1'b1;
            periodic_nxt = 1'b0;
            rm_nxt       = 1'b0;
            period_nxt   = '0;
            cmp_nxt      = (cmd.func == FUNC_SET_ABS) ? cmd.value : cmd.rel_cmp;
          end
        end
        FUNC_SET_PER: begin
          if (sel && !cmd.refuse) begin
            armed_nxt    = 1'b1;
            periodic_nxt = 1'b1;
            rm_nxt       = cmd.reset_on_match;
            period_nxt   = cmd.value;
            cmp_nxt      = cmd.value;
          end
        end
        FUNC_CLEAR: begin
          if (sel) begin
            armed_nxt    = 1'b0;
            periodic_nxt = 1'b0;
            rm_nxt       = 1'b0;
            period_nxt   = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= 1'b0;
      periodic_r <= 1'b0;
      rm_r       <= 1'b0;
    end else begin
      armed_r    <= armed_nxt;
      periodic_r <= periodic_nxt;
      rm_r       <= rm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_r    <= cmp_nxt;
    period_r <= period_nxt;
  end

`ifndef SYNTHESIS
  a_oneshot_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (fired && !periodic_r && cmd.en) |=> !armed_r)
    else $error("one-shot channel still armed after firing");

  a_rm_needs_periodic: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.en && sel && cmd.func == FUNC_SET_ABS) |=> (armed_r && !periodic_r && !rm_r))
    else $error("absolute set left channel in periodic mode");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.en && sel && cmd.func == FUNC_CLEAR) |=> !stat.fired)
    else $error("cleared channel fired");
`endif

endmodule

### hw/rtl/mct_ctrl.sv
// Counter, prescaler, run state, divider register and per-request decode.
module mct_ctrl #(
  parameter int CHANNELS = mct_pkg::CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic [mct_pkg::FUNC_W-1:0]         func,
  input  logic [mct_pkg::CHAN_W-1:0]         chan,
  input  logic [mct_pkg::CNT_W-1:0]          value,
  input  logic [mct_pkg::FLAGS_W-1:0]        flags,
  input  logic                               cfg_we,
  input  logic [mct_pkg::DIV_W-1:0]          cfg_data,
  input  mct_pkg::chan_stat_t [CHANNELS-1:0] stat,
  output mct_pkg::chan_cmd_t                 cmd,
  output mct_pkg::result_t                   res
);
  import mct_pkg::*;

  logic [CNT_W-1:0]   counter_r, counter_nxt;
  logic [PRE_W-1:0]   pre_r, pre_nxt;
  logic               running_r, running_nxt;
  logic [DIV_W-1:0]   div_sel_r;
  logic [PRE_W:0]     divisor;
  logic [PRE_W:0]     pre_inc;
  logic               step;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   cnt_add;
  func_t              fn;
  logic [CHANNELS-1:0] sel_vec;
  logic [CHANNELS-1:0] fired_vec;
  logic [CHANNELS-1:0] rm_vec;
  logic               chan_ok;
  logic               refuse;
  logic               zero_any;
  logic               per_ok;

  assign fn      = func_t'(func);
  assign divisor = (PRE_W+1)'(1) << div_sel_r;
  assign pre_inc = {1'b0, pre_r} + (PRE_W+1)'(1);
  assign step    = running_r && (pre_inc >= divisor);
  assign cnt_inc = counter_r + CNT_W'(1);
  assign cnt_add = counter_r + value;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      sel_vec[i]   = (int'(chan) == i);
      fired_vec[i] = stat[i].fired;
      rm_vec[i]    = stat[i].rm_active;
    end
  end

  assign chan_ok  = |sel_vec;
  assign refuse   = flags[FLAG_RESET_ON_MATCH] && |(rm_vec & ~sel_vec);
  assign zero_any = |(fired_vec & rm_vec);
  assign per_ok   = (fn == FUNC_SET_PER) && chan_ok && !refuse;

  always_comb begin
    cmd.en             = en;
    cmd.func           = fn;
    cmd.chan           = chan;
    cmd.step           = step;
    cmd.refuse         = refuse;
    cmd.reset_on_match = flags[FLAG_RESET_ON_MATCH];
    cmd.value          = value;
    cmd.rel_cmp        = (value == '0) ? cnt_inc : cnt_add;
    cmd.cnt_inc        = cnt_inc;
  end

  always_comb begin
    counter_nxt = counter_r;
    pre_nxt     = pre_r;
    running_nxt = running_r;
    unique case (fn)
      FUNC_TICK: begin
        if (running_r) begin
          if (step) begin
            pre_nxt     = '0;
            counter_nxt = zero_any ? '0 : cnt_inc;
          end else begin
            pre_nxt = pre_inc[PRE_W-1:0];
          end
        end
      end
      FUNC_SET_PER: begin
        if (per_ok) begin
          running_nxt = !flags[FLAG_LEAVE_STOPPED];
          if (flags[FLAG_ZERO_COUNTER]) begin
            counter_nxt = '0;
          end
        end
      end
      FUNC_START: running_nxt = 1'b1;
      FUNC_STOP:  running_nxt = 1'b0;
      default: begin
      end
    endcase
  end

  generate
    for (genvar g = 0; g < FIRED_W; g++) begin : g_mask
      if (g < CHANNELS) begin : g_used
        assign res.fired_mask[g] = fired_vec[g];
      end else begin : g_unused
        assign res.fired_mask[g] = 1'b0;
      end
    end
  endgenerate

  assign res.status    = (fn == FUNC_SET_PER) && chan_ok && refuse;
  assign res.count_now = counter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
      pre_r     <= '0;
      running_r <= 1'b1;
      div_sel_r <= '0;
    end else begin
      if (en) begin
        counter_r <= counter_nxt;
        pre_r     <= pre_nxt;
        running_r <= running_nxt;
      end
      if (cfg_we) begin
        div_sel_r <= cfg_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_status_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    res.status |-> (res.fired_mask == '0))
    else $error("refused request reports fired channels");

  a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (en && fn == FUNC_STOP) |=> !running_r)
    else $error("timer still running after stop");

  a_counter_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(counter_r))
    else $error("counter moved without a request");

  a_no_fire_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (fired_vec == '0))
    else $error("channel fired while stopped");
`endif

endmodule

### hw/rtl/multichannel_compare_timer_top.sv
// A request waits in the request register until the result register is free;
// then its result is written there. Throughput: one request per cycle unless
// out_ready stalls; the single-pass request-to-result update sets that figure.
// Reset: counter and prescaler zero, timer running, all channels disarmed,
// divider select zero.
module multichannel_compare_timer_top #(
  parameter int CHANNELS = mct_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mct_pkg::FUNC_W-1:0]    in_func,
  input  logic [mct_pkg::CHAN_W-1:0]    in_channel,
  input  logic [mct_pkg::CNT_W-1:0]     in_value,
  input  logic [mct_pkg::FLAGS_W-1:0]   in_mode_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [mct_pkg::FIRED_W-1:0]   out_fired_mask,
  output logic [mct_pkg::CNT_W-1:0]     out_count_now,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mct_pkg::DIV_W-1:0]     cfg_data
);
  import mct_pkg::*;

  logic                in_valid_r, in_valid_nxt;
  logic [FUNC_W-1:0]   func_r;
  logic [CHAN_W-1:0]   chan_r;
  logic [CNT_W-1:0]    value_r;
  logic [FLAGS_W-1:0]  flags_r;
  logic                out_valid_r, out_valid_nxt;
  result_t             res_r;
  result_t             res;
  chan_cmd_t           cmd;
  chan_stat_t [CHANNELS-1:0] stat;
  logic                adv;
  logic                in_take;

  assign adv       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || adv;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign in_valid_nxt  = in_take || (in_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r  <= in_func;
      chan_r  <= in_channel;
      value_r <= in_value;
      flags_r <= in_mode_flags;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  mct_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .func     (func_r),
    .chan     (chan_r),
    .value    (value_r),
    .flags    (flags_r),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .stat     (stat),
    .cmd      (cmd),
    .res      (res)
  );

  generate
    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
      mct_chan #(
        .CH_IDX (g)
      ) u_chan (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat[g])
      );
    end
  endgenerate

  assign out_valid      = out_valid_r;
  assign out_status     = res_r.status;
  assign out_fired_mask = res_r.fired_mask;
  assign out_count_now  = res_r.count_now;

`ifndef SYNTHESIS
  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("processed request produced no result");

  a_adv_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_valid_r)
    else $error("accepted request lost");
`endif

endmodule
